// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the scalar Kalman filter RTL.
// No dependencies; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, switched off while reset is held.
`define SKF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("skf: assertion failed");
// Clocked check that also holds through reset.
`define SKF_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("skf: assertion failed");
`else
`define SKF_ASSERT(lbl, clk, rst_n, prop)
`define SKF_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ===== hdl/skf_pkg.sv =====
// Package for the scalar Kalman filter: widths, register indices, reset values.
// No dependencies.
package skf_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int SAMPLE_BITS_DEF = 13;

  localparam int REG_BITS     = 24;
  localparam int REG_IDX_BITS = 2;
  localparam int COV_BITS     = 32;
  localparam int EST_BITS     = 32;

  localparam logic [REG_IDX_BITS-1:0] REG_PNOISE = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_MNOISE = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_ICOV   = 2'd2;

  // 2.0 in Q8.16
  localparam logic [REG_BITS-1:0] RESET_NOISE = 24'd131072;

endpackage

// ===== hdl/skf_in_if.sv =====
// Sample request channel of the scalar Kalman filter.
// Depends on skf_pkg for the default sample width.
interface skf_in_if
  import skf_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== hdl/skf_out_if.sv =====
// Result request channel of the scalar Kalman filter.
// Depends on skf_pkg for the default sample width.
interface skf_out_if
  import skf_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

// ===== hdl/scalar_kalman_filter_core.sv =====
// Scalar Kalman filter core: one sample in, one filtered estimate out.
// Depends on skf_pkg, skf_in_if, skf_out_if and assert_macros.svh.
//
// Each sample runs through a small sequencer around one shared adder/subtractor:
// covariance predict (S_PRED), gain denominator (S_DEN) and innovation (S_DIF1,
// S_DIF2) come first, the gain p/(p+r) is a restoring division with one quotient
// bit per cycle, and the estimate and covariance updates are each a shift-add
// multiply by the gain or by one minus the gain. in_s.ready is high only while the
// sequencer is idle, so a new request is taken only once the last one has left the
// sequencer. The result sits in an output register so the next sample can be
// taken while it waits; a result still held there stalls the next one in its
// final state, S_FIN. Configuration writes must happen while the core is idle;
// writing the initial covariance also loads it into the running covariance.
`include "assert_macros.svh"

module scalar_kalman_filter_core
  import skf_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  skf_in_if.sink                  in_s,
  skf_out_if.source               out_s,
  input  logic                    cfg_we,
  input  logic [REG_IDX_BITS-1:0] cfg_idx,
  input  logic [REG_BITS-1:0]     cfg_wdata
);

  localparam int F  = FRAC_BITS;
  localparam int S  = SAMPLE_BITS;
  localparam int GW = F + 1;                              // gain width, 0 ..= 1.0
  localparam int TW = S + F;                              // target width
  localparam int DW = ((TW > EST_BITS) ? TW : EST_BITS) + 1; // innovation magnitude
  localparam int WA = DW + GW;                            // shared adder width
  localparam int NW = COV_BITS + 1;                       // denominator
  localparam int RW = COV_BITS + 2;                       // division remainder
  localparam int CW = $clog2(GW);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PRED  = 4'd1;
  localparam logic [3:0] S_DEN   = 4'd2;
  localparam logic [3:0] S_DIF1  = 4'd3;
  localparam logic [3:0] S_DIF2  = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_MULX  = 4'd6;
  localparam logic [3:0] S_APPLY = 4'd7;
  localparam logic [3:0] S_MULP  = 4'd8;
  localparam logic [3:0] S_COV   = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  localparam logic [CW-1:0]       CNT_LAST = CW'(F);
  localparam logic [GW-1:0]       ONE_FIX  = GW'(1) << F;
  localparam logic [EST_BITS-1:0] EST_MAX  = {1'b0, {(EST_BITS-1){1'b1}}};
  localparam logic [EST_BITS-1:0] EST_MIN  = {1'b1, {(EST_BITS-1){1'b0}}};
  localparam logic [31:0]         HALF     = 32'(1) << (S - 1);
  localparam logic [S-1:0]        OUT_MAX  = {1'b0, {(S-1){1'b1}}};
  localparam logic [S-1:0]        OUT_MIN  = {1'b1, {(S-1){1'b0}}};

  logic [3:0]          state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [REG_BITS-1:0] pnoise_r, pnoise_nxt;
  logic [REG_BITS-1:0] mnoise_r, mnoise_nxt;
  logic [EST_BITS-1:0] est_r, est_nxt;
  logic [COV_BITS-1:0] cov_r, cov_nxt;
  logic [S-1:0]        sample_r, sample_nxt;
  logic [COV_BITS-1:0] p1_r, p1_nxt;
  logic [NW-1:0]       den_r, den_nxt;
  logic [RW-1:0]       rem_r, rem_nxt;
  logic [GW-1:0]       gain_r, gain_nxt;
  logic [GW-1:0]       mult_r, mult_nxt;
  logic                dneg_r, dneg_nxt;
  logic [DW-1:0]       dmag_r, dmag_nxt;
  logic [WA-1:0]       acc_r, acc_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [S-1:0]        filt_r, filt_nxt;

  // shared adder
  logic [WA-1:0] alu_a, alu_b, alu_y;
  logic          alu_sub;

  logic [WA-1:0]       target_w, est_ext_w, step_w;
  logic                div_ge;
  logic [GW-1:0]       quo_w;
  logic                est_fits;
  logic [EST_BITS-1:0] est_mag_w;
  logic [31:0]         whole_w;
  logic [S-1:0]        filt_w;
  logic                out_free;

  assign target_w  = {{(WA-S){sample_r[S-1]}}, sample_r} << F;
  assign est_ext_w = {{(WA-EST_BITS){est_r[EST_BITS-1]}}, est_r};
  assign step_w    = {{(WA-DW){1'b0}}, acc_r[F +: DW]};

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      S_PRED: begin
        alu_a = WA'(cov_r);
        alu_b = WA'(pnoise_r);
      end
      S_DEN: begin
        alu_a = WA'(p1_r);
        alu_b = WA'(mnoise_r);
      end
      S_DIF1: begin
        alu_a   = target_w;
        alu_b   = est_ext_w;
        alu_sub = 1'b1;
      end
      S_DIF2: begin
        alu_a   = dneg_r ? est_ext_w : target_w;
        alu_b   = dneg_r ? target_w : est_ext_w;
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = WA'(rem_r);
        alu_b   = WA'(den_r);
        alu_sub = 1'b1;
      end
      S_MULX: begin
        alu_a = {acc_r[WA-2:0], 1'b0};
        alu_b = mult_r[GW-1] ? WA'(dmag_r) : '0;
      end
      S_APPLY: begin
        alu_a   = est_ext_w;
        alu_b   = step_w;
        alu_sub = dneg_r;
      end
      S_MULP: begin
        alu_a = {acc_r[WA-2:0], 1'b0};
        alu_b = mult_r[GW-1] ? WA'(p1_r) : '0;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
    alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  end

  assign div_ge   = ~alu_y[WA-1];
  assign quo_w    = {gain_r[GW-2:0], div_ge};
  assign est_fits = (&alu_y[WA-1:EST_BITS-1]) | ~(|alu_y[WA-1:EST_BITS-1]);

  // output conversion, truncation toward zero, saturating to the sample range
  assign est_mag_w = est_r[EST_BITS-1] ? (EST_BITS'(0) - est_r) : est_r;
  assign whole_w   = 32'(est_mag_w >> F);

  always_comb begin
    if (est_r[EST_BITS-1]) begin
      filt_w = (whole_w > HALF) ? OUT_MIN : S'(32'd0 - whole_w);
    end else begin
      filt_w = (whole_w > HALF - 32'd1) ? OUT_MAX : whole_w[S-1:0];
    end
  end

  assign out_free = ~out_valid_r | out_s.ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pnoise_nxt    = pnoise_r;
    mnoise_nxt    = mnoise_r;
    est_nxt       = est_r;
    cov_nxt       = cov_r;
    sample_nxt    = sample_r;
    p1_nxt        = p1_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    gain_nxt      = gain_r;
    mult_nxt      = mult_r;
    dneg_nxt      = dneg_r;
    dmag_nxt      = dmag_r;
    acc_nxt       = acc_r;
    filt_nxt      = filt_r;
    out_valid_nxt = out_valid_r & ~out_s.ready;

    case (state_r)
      S_IDLE: begin
        if (in_s.valid) begin
          sample_nxt = in_s.sample;
          state_nxt  = S_PRED;
        end
      end
      S_PRED: begin
        // covariance saturates at all ones
        p1_nxt    = (|alu_y[WA-1:COV_BITS]) ? '1 : alu_y[COV_BITS-1:0];
        state_nxt = S_DEN;
      end
      S_DEN: begin
        den_nxt   = alu_y[NW-1:0];
        rem_nxt   = RW'(p1_r);
        state_nxt = S_DIF1;
      end
      S_DIF1: begin
        dneg_nxt  = alu_y[WA-1];
        state_nxt = S_DIF2;
      end
      S_DIF2: begin
        dmag_nxt  = alu_y[DW-1:0];
        gain_nxt  = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt  = div_ge ? {alu_y[RW-2:0], 1'b0} : {rem_r[RW-2:0], 1'b0};
        gain_nxt = quo_w;
        cnt_nxt  = cnt_r + CW'(1);
        if (cnt_r == CNT_LAST) begin
          // zero denominator leaves estimate and covariance untouched
          gain_nxt  = (den_r == '0) ? '0 : quo_w;
          mult_nxt  = (den_r == '0) ? '0 : quo_w;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_MULX;
        end
      end
      S_MULX: begin
        acc_nxt  = alu_y;
        mult_nxt = {mult_r[GW-2:0], 1'b0};
        cnt_nxt  = cnt_r + CW'(1);
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        if (est_fits) begin
          est_nxt = alu_y[EST_BITS-1:0];
        end else begin
          est_nxt = alu_y[WA-1] ? EST_MIN : EST_MAX;
        end
        mult_nxt  = ONE_FIX - gain_r;
        acc_nxt   = '0;
        state_nxt = S_MULP;
      end
      S_MULP: begin
        acc_nxt  = alu_y;
        mult_nxt = {mult_r[GW-2:0], 1'b0};
        cnt_nxt  = cnt_r + CW'(1);
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_COV;
        end
      end
      S_COV: begin
        cov_nxt   = acc_r[F +: COV_BITS];
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          filt_nxt      = filt_w;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      case (cfg_idx)
        REG_PNOISE: pnoise_nxt = cfg_wdata;
        REG_MNOISE: mnoise_nxt = cfg_wdata;
        REG_ICOV:   cov_nxt    = COV_BITS'(cfg_wdata);
        default:    pnoise_nxt = pnoise_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pnoise_r    <= RESET_NOISE;
      mnoise_r    <= RESET_NOISE;
      est_r       <= '0;
      cov_r       <= COV_BITS'(RESET_NOISE);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pnoise_r    <= pnoise_nxt;
      mnoise_r    <= mnoise_nxt;
      est_r       <= est_nxt;
      cov_r       <= cov_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
    p1_r     <= p1_nxt;
    den_r    <= den_nxt;
    rem_r    <= rem_nxt;
    gain_r   <= gain_nxt;
    mult_r   <= mult_nxt;
    dneg_r   <= dneg_nxt;
    dmag_r   <= dmag_nxt;
    acc_r    <= acc_nxt;
    filt_r   <= filt_nxt;
  end

  assign in_s.ready     = (state_r == S_IDLE);
  assign out_s.valid    = out_valid_r;
  assign out_s.filtered = filt_r;

  `SKF_ASSERT(a_accept_starts, clk, rst_n, (in_s.valid && in_s.ready) |=> (state_r == S_PRED))
  `SKF_ASSERT(a_result_from_fin, clk, rst_n, $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
  `SKF_ASSERT(a_gain_bound, clk, rst_n, (state_r == S_MULX) |-> (gain_r <= ONE_FIX))
  `SKF_ASSERT(a_cov_fits, clk, rst_n, (state_r == S_COV) |-> (acc_r[WA-1:F+COV_BITS] == '0))
  `SKF_ASSERT_NR(a_reset_clears_out, clk, (!rst_n) |=> (!out_s.valid))

endmodule

// ===== tb/tb_scalar_kalman_filter_core.sv =====
// Self-checking bench for scalar_kalman_filter_core: drives samples and noise settings,
// predicts each filtered estimate in a scoreboard class and checks every result.
// Depends on skf_pkg, skf_in_if, skf_out_if and the core itself.
`timescale 1ns / 1ps

module tb_scalar_kalman_filter_core;
  import skf_pkg::*;

  localparam int SMP_W = SAMPLE_BITS_DEF;
  localparam int FRAC_W = FRAC_BITS_DEF;
  localparam logic [REG_IDX_BITS-1:0] REG_SPARE = 2'd3;
  localparam logic [REG_BITS-1:0] REG_FULL = '1;
  localparam longint EST_HI = (longint'(1) << 31) - 1;
  localparam longint EST_LO = -(longint'(1) << 31);
  localparam int OUT_HI = (1 << (SMP_W - 1)) - 1;
  localparam int OUT_LO = -(1 << (SMP_W - 1));
  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD = 400;
  localparam int PHASE_ITEMS = 108;
  localparam int NUM_PHASES = 10;
  localparam int SETTLE_CYCLES = 70;

  class kalman_scoreboard;
    logic [REG_BITS-1:0] proc_noise, meas_noise, init_cov;
    logic signed [31:0] estimate;
    logic [31:0] covariance;
    logic signed [SMP_W-1:0] filtered_q[$];
    int fails;

    function void clear();
      proc_noise = RESET_NOISE;
      meas_noise = RESET_NOISE;
      init_cov = RESET_NOISE;
      estimate = '0;
      covariance = 32'(RESET_NOISE);
      filtered_q.delete();
      fails = 0;
    endfunction

    function void write_reg(logic [REG_IDX_BITS-1:0] idx, logic [REG_BITS-1:0] val);
      case (idx)
        REG_PNOISE: proc_noise = val;
        REG_MNOISE: meas_noise = val;
        REG_ICOV: begin
          init_cov = val;
          covariance = 32'(val);
        end
        default: ;
      endcase
    endfunction

    function int pending();
      return filtered_q.size();
    endfunction

    // one filter step per accepted request
    function void note_sample(logic signed [SMP_W-1:0] smp);
      longint unsigned p1, den, gain, mag, step;
      longint diff, nx, whole;
      p1 = 64'(covariance) + 64'(proc_noise);
      if (p1 > 64'hFFFF_FFFF) p1 = 64'hFFFF_FFFF;
      den = p1 + 64'(meas_noise);
      gain = (den == 0) ? 64'd0 : (p1 << FRAC_W) / den;
      diff = longint'(smp) * (longint'(1) << FRAC_W) - longint'(estimate);
      mag = (diff < 0) ? 64'(-diff) : 64'(diff);
      step = (mag * gain) >> FRAC_W;
      nx = (diff < 0) ? longint'(estimate) - longint'(step)
                      : longint'(estimate) + longint'(step);
      if (nx > EST_HI) nx = EST_HI;
      else if (nx < EST_LO) nx = EST_LO;
      estimate = 32'(nx);
      covariance = 32'((p1 * ((64'd1 << FRAC_W) - gain)) >> FRAC_W);
      // truncate toward zero, then clip to the sample range
      mag = (estimate < 0) ? 64'(-longint'(estimate)) : 64'(longint'(estimate));
      whole = longint'(mag >> FRAC_W);
      if (estimate < 0) whole = -whole;
      if (whole > OUT_HI) whole = OUT_HI;
      else if (whole < OUT_LO) whole = OUT_LO;
      filtered_q.push_back(SMP_W'(whole));
    endfunction

    task report(string msg);
      fails++;
      if (fails <= 40) $display("[%0t] %s", $time, msg);
    endtask

    task check_result(logic signed [SMP_W-1:0] got);
      logic signed [SMP_W-1:0] want;
      if (filtered_q.size() == 0) begin
        report($sformatf("filtered %0d arrived with no request pending", got));
      end else begin
        want = filtered_q.pop_front();
        if (got !== want) report($sformatf("filtered got %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [REG_IDX_BITS-1:0] cfg_idx;
  logic [REG_BITS-1:0] cfg_wdata;
  logic calm = 1'b0;
  logic long_hold_req = 1'b0;
  logic long_hold_done = 1'b0;
  int rx_hold = 0;
  int quiet_cycles = 0;
  kalman_scoreboard sb;

  skf_in_if in_ch ();
  skf_out_if out_ch ();

  scalar_kalman_filter_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_ch),
    .out_s     (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: short random stalls, or one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        rx_hold = LONG_HOLD;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        rx_hold = $urandom_range(0, 5);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_sample(in_ch.sample);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.filtered);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_scalar_kalman_filter_core NOT OK");
        $finish;
      end
    end
  end

  task automatic offer_sample(input logic signed [SMP_W-1:0] smp);
    int gap;
    int bursts;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) begin
      // now and then chain bursts so gaps reach across a whole request
      bursts = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 12) : 1;
      for (int k = 0; k < bursts; k++) gap += $urandom_range(1, 6);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= smp;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx,
                           input logic [REG_BITS-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  initial begin : stimulus
    int extremes[8] = '{4095, -4096, 0, -1, 1, 4095, 4095, -4096};
    int level, run_left, v;
    logic signed [SMP_W-1:0] raw;
    logic [REG_BITS-1:0] q_set, r_set, c_set;
    sb = new();
    sb.clear();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings, sample extremes
    foreach (extremes[k]) offer_sample(SMP_W'(extremes[k]));
    drain();
    write_reg(REG_SPARE, 24'h5A5A5A);

    // zero denominator: gain stays zero, estimate and covariance hold
    write_reg(REG_PNOISE, '0);
    write_reg(REG_MNOISE, '0);
    write_reg(REG_ICOV, '0);
    offer_sample(SMP_W'(4095));
    offer_sample(SMP_W'(-4096));
    offer_sample(SMP_W'(100));
    drain();

    // no measurement noise: unity gain, estimate snaps to each sample
    write_reg(REG_PNOISE, REG_FULL);
    write_reg(REG_ICOV, REG_FULL);
    offer_sample(SMP_W'(-4096));
    offer_sample(SMP_W'(4095));
    offer_sample(SMP_W'(1234));
    drain();

    write_reg(REG_MNOISE, REG_FULL);
    offer_sample(SMP_W'(-1));
    offer_sample(SMP_W'(0));
    offer_sample(SMP_W'(4095));
    drain();

    write_reg(REG_PNOISE, '0);
    write_reg(REG_MNOISE, 24'd1);
    write_reg(REG_ICOV, '0);
    offer_sample(SMP_W'(7));
    offer_sample(SMP_W'(-7));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          q_set = RESET_NOISE;
          r_set = RESET_NOISE;
          c_set = RESET_NOISE;
        end
        1: begin
          q_set = '0;
          r_set = REG_FULL;
          c_set = REG_FULL;
        end
        2: begin
          q_set = REG_FULL;
          r_set = 24'd1;
          c_set = '0;
        end
        4: begin
          q_set = 24'd1;
          r_set = 24'd1;
          c_set = 24'd1;
        end
        6: begin
          q_set = REG_FULL;
          r_set = REG_FULL;
          c_set = REG_FULL;
        end
        7: begin
          q_set = REG_BITS'($urandom_range(0, 'hFFFF));
          r_set = REG_BITS'($urandom_range(1, 'hFFFF));
          c_set = REG_BITS'($urandom_range(0, 'hFFFF));
        end
        default: begin
          q_set = REG_BITS'($urandom);
          r_set = REG_BITS'($urandom_range(1, REG_FULL));
          c_set = REG_BITS'($urandom);
        end
      endcase
      write_reg(REG_PNOISE, q_set);
      write_reg(REG_MNOISE, r_set);
      write_reg(REG_ICOV, c_set);
      calm = (ph == 7 || ph == NUM_PHASES - 1);
      run_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == 20) long_hold_req = 1'b1;
        if (ph == 5 && n == PHASE_ITEMS / 2) drain();
        // mostly noisy runs around a level, the rest wild samples
        if (run_left == 0) begin
          raw = SMP_W'($urandom);
          level = int'(raw);
          run_left = $urandom_range(4, 30);
        end
        run_left--;
        if ($urandom_range(0, 4) == 0) begin
          raw = SMP_W'($urandom);
        end else begin
          v = level + int'($urandom_range(0, 128)) - 64;
          if (v > OUT_HI) v = OUT_HI;
          if (v < OUT_LO) v = OUT_LO;
          raw = SMP_W'(v);
        end
        offer_sample(raw);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("tb_scalar_kalman_filter_core OK");
    end else begin
      $display("tb_scalar_kalman_filter_core NOT OK");
    end
    $finish;
  end

endmodule
